### hdl/sfc_pkg.sv
package sfc_pkg;

    localparam int BYTE_W  = 8;
    localparam int CODE_W  = 16;
    localparam int MODE_W  = 2;
    localparam int INDEX_W = 3;
    localparam int STAT_W  = 5;

    localparam logic [INDEX_W-1:0] REG_HEADER_FIRST  = 3'd0;
    localparam logic [INDEX_W-1:0] REG_HEADER_SECOND = 3'd1;
    localparam logic [INDEX_W-1:0] REG_TAIL_FIRST    = 3'd2;
    localparam logic [INDEX_W-1:0] REG_TAIL_SECOND   = 3'd3;
    localparam logic [INDEX_W-1:0] REG_CHECK_MODE    = 3'd4;

    localparam logic [MODE_W-1:0] MODE_NONE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SUM16 = 2'd1;
    localparam logic [MODE_W-1:0] MODE_XOR8  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CRC16 = 2'd3;

    localparam logic [CODE_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CODE_W-1:0] CRC_POLY = 16'hA001;

    localparam int STAT_CHECK_BIT  = 0;
    localparam int STAT_HEADER_BIT = 1;
    localparam int STAT_TAIL_BIT   = 4;

    // where the current beat falls in the frame
    typedef struct packed {
        logic first;
        logic second;
        logic payload;
        logic check_high;
        logic check_low;
        logic tail_first;
        logic last;
    } byte_ctl_t;

    function automatic logic [CODE_W-1:0] crc16_byte(
        input logic [CODE_W-1:0] crc_in,
        input logic [BYTE_W-1:0] data
    );
        logic [CODE_W-1:0] crc;
        crc = crc_in ^ {{(CODE_W-BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

### hdl/sfc_position.sv
module sfc_position #(
    parameter int FRAME_LEN = 22
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    output sfc_pkg::byte_ctl_t ctl
);

    localparam int POS_W = $clog2(FRAME_LEN);
    localparam logic [POS_W-1:0] POS_LAST       = POS_W'(FRAME_LEN - 1);
    localparam logic [POS_W-1:0] POS_TAIL_FIRST = POS_W'(FRAME_LEN - 2);
    localparam logic [POS_W-1:0] POS_CHECK_LOW  = POS_W'(FRAME_LEN - 3);
    localparam logic [POS_W-1:0] POS_CHECK_HIGH = POS_W'(FRAME_LEN - 4);
    localparam logic [POS_W-1:0] POS_SECOND     = POS_W'(1);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;

    always_comb begin
        ctl.first      = (pos_reg == '0);
        ctl.second     = (pos_reg == POS_SECOND);
        ctl.payload    = (pos_reg > POS_SECOND) && (pos_reg < POS_CHECK_HIGH);
        ctl.check_high = (pos_reg == POS_CHECK_HIGH);
        ctl.check_low  = (pos_reg == POS_CHECK_LOW);
        ctl.tail_first = (pos_reg == POS_TAIL_FIRST);
        ctl.last       = (pos_reg == POS_LAST);
    end

    always_comb begin
        pos_next = pos_reg;
        if (step) begin
            pos_next = ctl.last ? '0 : pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

endmodule

### hdl/sfc_check.sv
module sfc_check (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                step,
    input  sfc_pkg::byte_ctl_t                  ctl,
    input  logic [sfc_pkg::BYTE_W-1:0]          rx_byte,
    input  logic [sfc_pkg::MODE_W-1:0]          check_mode,
    output logic                                check_bad
);

    logic [sfc_pkg::CODE_W-1:0] sum_reg;
    logic [sfc_pkg::CODE_W-1:0] sum_next;
    logic [sfc_pkg::BYTE_W-1:0] xor_reg;
    logic [sfc_pkg::BYTE_W-1:0] xor_next;
    logic [sfc_pkg::CODE_W-1:0] crc_reg;
    logic [sfc_pkg::CODE_W-1:0] crc_next;
    logic [sfc_pkg::BYTE_W-1:0] high_reg;
    logic [sfc_pkg::BYTE_W-1:0] high_next;
    logic                       bad_reg;
    logic                       bad_next;
    logic [sfc_pkg::CODE_W-1:0] received;
    logic                       compare_bad;

    assign received = {high_reg, rx_byte};

    always_comb begin
        unique case (check_mode)
            sfc_pkg::MODE_SUM16: compare_bad = (sum_reg != received);
            sfc_pkg::MODE_XOR8:  compare_bad = (xor_reg != rx_byte);
            sfc_pkg::MODE_CRC16: compare_bad = (crc_reg != received);
            default:             compare_bad = 1'b0;
        endcase
    end

    always_comb begin
        sum_next  = sum_reg;
        xor_next  = xor_reg;
        crc_next  = crc_reg;
        high_next = high_reg;
        bad_next  = bad_reg;
        if (step) begin
            if (ctl.first) begin
                sum_next = '0;
                xor_next = '0;
                crc_next = sfc_pkg::CRC_INIT;
                bad_next = 1'b0;
            end else if (ctl.payload) begin
                sum_next = sum_reg + {{(sfc_pkg::CODE_W-sfc_pkg::BYTE_W){1'b0}}, rx_byte};
                xor_next = xor_reg ^ rx_byte;
                crc_next = sfc_pkg::crc16_byte(crc_reg, rx_byte);
            end else if (ctl.check_high) begin
                high_next = rx_byte;
            end else if (ctl.check_low) begin
                bad_next = compare_bad;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg  <= '0;
            xor_reg  <= '0;
            crc_reg  <= sfc_pkg::CRC_INIT;
            high_reg <= '0;
            bad_reg  <= 1'b0;
        end else begin
            sum_reg  <= sum_next;
            xor_reg  <= xor_next;
            crc_reg  <= crc_next;
            high_reg <= high_next;
            bad_reg  <= bad_next;
        end
    end

    assign check_bad = bad_reg;

endmodule

### hdl/serial_frame_checker_unit.sv
// channel   | handshake          | beat payload
// ----------+--------------------+-------------------------------------------------
// input     | s_valid / s_ready  | s_rx_byte, s_clear_errors
// result    | m_valid / m_ready  | m_header_bad, m_tail_bad, m_check_bad,
//           |                    | m_error_status
// config    | cfg_we             | cfg_index, cfg_wdata
//
// one byte per cycle while s_ready is high; sum, xor and crc of a byte update in the cycle it is taken
// the result of a frame shows in the cycle after its last byte is accepted
// s_ready drops only while the position is at the last byte of a frame, the previous
// result is still held and m_ready is low
// synchronous active-low reset clears position, running codes, flags and config
module serial_frame_checker_unit #(
    parameter int FRAME_LEN = 22
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [sfc_pkg::BYTE_W-1:0]          s_rx_byte,
    input  logic                                s_clear_errors,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_header_bad,
    output logic                                m_tail_bad,
    output logic                                m_check_bad,
    output logic [sfc_pkg::STAT_W-1:0]          m_error_status,
    input  logic                                cfg_we,
    input  logic [sfc_pkg::INDEX_W-1:0]         cfg_index,
    input  logic [sfc_pkg::BYTE_W-1:0]          cfg_wdata
);

    logic [sfc_pkg::BYTE_W-1:0] header_first_reg;
    logic [sfc_pkg::BYTE_W-1:0] header_second_reg;
    logic [sfc_pkg::BYTE_W-1:0] tail_first_reg;
    logic [sfc_pkg::BYTE_W-1:0] tail_second_reg;
    logic [sfc_pkg::MODE_W-1:0] check_mode_reg;

    sfc_pkg::byte_ctl_t ctl;
    logic step;
    logic check_bad;

    logic hdr_bad_reg;
    logic hdr_bad_next;
    logic tail_bad_reg;
    logic tail_bad_next;
    logic [sfc_pkg::STAT_W-1:0] sticky_reg;
    logic [sfc_pkg::STAT_W-1:0] sticky_next;
    logic [sfc_pkg::STAT_W-1:0] sticky_base;
    logic [sfc_pkg::STAT_W-1:0] frame_flags;
    logic tail_final;

    logic                       m_valid_reg;
    logic                       m_valid_next;
    logic                       m_header_bad_reg;
    logic                       m_tail_bad_reg;
    logic                       m_check_bad_reg;
    logic [sfc_pkg::STAT_W-1:0] m_status_reg;

    assign s_ready = !(ctl.last && m_valid_reg && !m_ready);
    assign step    = s_valid && s_ready;

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_first_reg  <= '0;
            header_second_reg <= '0;
            tail_first_reg    <= '0;
            tail_second_reg   <= '0;
            check_mode_reg    <= sfc_pkg::MODE_NONE;
        end else if (cfg_we) begin
            unique case (cfg_index)
                sfc_pkg::REG_HEADER_FIRST:  header_first_reg  <= cfg_wdata;
                sfc_pkg::REG_HEADER_SECOND: header_second_reg <= cfg_wdata;
                sfc_pkg::REG_TAIL_FIRST:    tail_first_reg    <= cfg_wdata;
                sfc_pkg::REG_TAIL_SECOND:   tail_second_reg   <= cfg_wdata;
                sfc_pkg::REG_CHECK_MODE:    check_mode_reg    <= cfg_wdata[sfc_pkg::MODE_W-1:0];
                default: ;
            endcase
        end
    end

    sfc_position #(
        .FRAME_LEN(FRAME_LEN)
    ) u_position (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .ctl     (ctl)
    );

    sfc_check u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .ctl        (ctl),
        .rx_byte    (s_rx_byte),
        .check_mode (check_mode_reg),
        .check_bad  (check_bad)
    );

    assign tail_final  = tail_bad_reg || (s_rx_byte != tail_second_reg);
    assign sticky_base = s_clear_errors ? '0 : sticky_reg;

    always_comb begin
        frame_flags = '0;
        frame_flags[sfc_pkg::STAT_CHECK_BIT]  = check_bad;
        frame_flags[sfc_pkg::STAT_HEADER_BIT] = hdr_bad_reg;
        frame_flags[sfc_pkg::STAT_TAIL_BIT]   = tail_final;
    end

    always_comb begin
        hdr_bad_next  = hdr_bad_reg;
        tail_bad_next = tail_bad_reg;
        sticky_next   = sticky_reg;
        if (step) begin
            sticky_next = ctl.last ? (sticky_base | frame_flags) : sticky_base;
            if (ctl.first) begin
                hdr_bad_next  = (s_rx_byte != header_first_reg);
                tail_bad_next = 1'b0;
            end else if (ctl.second) begin
                hdr_bad_next = hdr_bad_reg || (s_rx_byte != header_second_reg);
            end else if (ctl.tail_first) begin
                tail_bad_next = (s_rx_byte != tail_first_reg);
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (step && ctl.last) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_bad_reg  <= 1'b0;
            tail_bad_reg <= 1'b0;
            sticky_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            hdr_bad_reg  <= hdr_bad_next;
            tail_bad_reg <= tail_bad_next;
            sticky_reg   <= sticky_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // result beat
    always_ff @(posedge aclk) begin
        if (step && ctl.last) begin
            m_header_bad_reg <= hdr_bad_reg;
            m_tail_bad_reg   <= tail_final;
            m_check_bad_reg  <= check_bad;
            m_status_reg     <= sticky_base | frame_flags;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_header_bad   = m_header_bad_reg;
    assign m_tail_bad     = m_tail_bad_reg;
    assign m_check_bad    = m_check_bad_reg;
    assign m_error_status = m_status_reg;

    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(step && ctl.last))
        else $error("result beat without a last byte");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && ctl.last) |-> (!m_valid_reg || m_ready))
        else $error("held result overwritten");

    a_status_covers_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((m_status_reg[sfc_pkg::STAT_CHECK_BIT] || !m_check_bad_reg)
                      && (m_status_reg[sfc_pkg::STAT_HEADER_BIT] || !m_header_bad_reg)
                      && (m_status_reg[sfc_pkg::STAT_TAIL_BIT] || !m_tail_bad_reg)))
        else $error("error status misses a frame flag");

    a_sticky_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(sticky_reg))
        else $error("sticky status changed without a byte");

endmodule

### verif/tb_serial_frame_checker_unit.sv
module tb_serial_frame_checker_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import sfc_pkg::*;

    localparam int FRAME_LEN    = 22;
    localparam int ITEM_TARGET  = 1550;
    localparam int SETTLE       = 4;
    localparam int HOLD_CYCLES  = 150;
    localparam int NO_CLEAR     = -1;

    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_kind_t;

    typedef struct packed {
        logic              header_bad;
        logic              tail_bad;
        logic              check_bad;
        logic [STAT_W-1:0] status;
    } frame_report_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [BYTE_W-1:0]    s_rx_byte;
    logic                 s_clear_errors;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_header_bad;
    logic                 m_tail_bad;
    logic                 m_check_bad;
    logic [STAT_W-1:0]    m_error_status;
    logic                 cfg_we;
    logic [INDEX_W-1:0]   cfg_index;
    logic [BYTE_W-1:0]    cfg_wdata;

    // register mirror
    logic [BYTE_W-1:0]    exp_hdr0, exp_hdr1, exp_tail0, exp_tail1;
    logic [MODE_W-1:0]    cur_mode;

    // frame tracking state
    int                   frame_pos;
    logic [CODE_W-1:0]    sum_acc;
    logic [BYTE_W-1:0]    xor_acc;
    logic [CODE_W-1:0]    crc_acc;
    logic [BYTE_W-1:0]    chk_hi;
    logic                 hdr_flag, tail_flag, chk_flag;
    logic [STAT_W-1:0]    sticky;

    frame_report_t        frame_reports[$];
    frame_report_t        want;
    logic [BYTE_W-1:0]    frame_buf[FRAME_LEN];

    int                   bytes_sent;
    int                   mismatches;
    int                   hold_request;
    bit                   tx_gaps;
    bit                   rx_stall;

    serial_frame_checker_unit #(.FRAME_LEN(FRAME_LEN)) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .s_clear_errors (s_clear_errors),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_header_bad   (m_header_bad),
        .m_tail_bad     (m_tail_bad),
        .m_check_bad    (m_check_bad),
        .m_error_status (m_error_status),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // lsb-first modbus crc, one data bit at a time
    function automatic logic [CODE_W-1:0] crc_fold_byte(
        input logic [CODE_W-1:0] crc_in,
        input logic [BYTE_W-1:0] b
    );
        logic [CODE_W-1:0] crc;
        logic              fb;
        crc = crc_in;
        for (int i = 0; i < BYTE_W; i++) begin
            fb  = crc[0] ^ b[i];
            crc = crc >> 1;
            if (fb) begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

    function automatic void clear_tracking();
        exp_hdr0  = '0;
        exp_hdr1  = '0;
        exp_tail0 = '0;
        exp_tail1 = '0;
        cur_mode  = MODE_NONE;
        frame_pos = 0;
        sum_acc   = '0;
        xor_acc   = '0;
        crc_acc   = CRC_INIT;
        chk_hi    = '0;
        hdr_flag  = 1'b0;
        tail_flag = 1'b0;
        chk_flag  = 1'b0;
        sticky    = '0;
    endfunction

    function automatic void follow_byte(input logic [BYTE_W-1:0] b, input logic clr);
        frame_report_t     rep;
        logic [CODE_W-1:0] recv;
        if (clr) begin
            sticky = '0;
        end
        if (frame_pos == 0) begin
            sum_acc   = '0;
            xor_acc   = '0;
            crc_acc   = CRC_INIT;
            tail_flag = 1'b0;
            chk_flag  = 1'b0;
            hdr_flag  = (b != exp_hdr0);
        end else if (frame_pos == 1) begin
            hdr_flag = hdr_flag | (b != exp_hdr1);
        end else if (frame_pos < FRAME_LEN - 4) begin
            sum_acc = sum_acc + {{(CODE_W - BYTE_W){1'b0}}, b};
            xor_acc = xor_acc ^ b;
            crc_acc = crc_fold_byte(crc_acc, b);
        end else if (frame_pos == FRAME_LEN - 4) begin
            chk_hi = b;
        end else if (frame_pos == FRAME_LEN - 3) begin
            recv = {chk_hi, b};
            case (cur_mode)
                MODE_SUM16: chk_flag = (sum_acc != recv);
                MODE_XOR8:  chk_flag = (xor_acc != b);
                MODE_CRC16: chk_flag = (crc_acc != recv);
                default:    chk_flag = 1'b0;
            endcase
        end else if (frame_pos == FRAME_LEN - 2) begin
            tail_flag = (b != exp_tail0);
        end
        if (frame_pos == FRAME_LEN - 1) begin
            tail_flag = tail_flag | (b != exp_tail1);
            if (chk_flag) sticky[STAT_CHECK_BIT] = 1'b1;
            if (hdr_flag) sticky[STAT_HEADER_BIT] = 1'b1;
            if (tail_flag) sticky[STAT_TAIL_BIT] = 1'b1;
            rep.header_bad = hdr_flag;
            rep.tail_bad   = tail_flag;
            rep.check_bad  = chk_flag;
            rep.status     = sticky;
            frame_reports.push_back(rep);
            frame_pos = 0;
        end else begin
            frame_pos++;
        end
    endfunction

    task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [BYTE_W-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            REG_HEADER_FIRST:  exp_hdr0  = data;
            REG_HEADER_SECOND: exp_hdr1  = data;
            REG_TAIL_FIRST:    exp_tail0 = data;
            REG_TAIL_SECOND:   exp_tail1 = data;
            REG_CHECK_MODE:    cur_mode  = data[MODE_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic clr);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 7) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_rx_byte      <= b;
        s_clear_errors <= clr;
        do @(posedge aclk); while (!s_ready);
        follow_byte(b, clr);
        bytes_sent++;
    endtask

    // stop offering beats and wait for every pending frame report
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (frame_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic send_span(input int first, input int last, input int clr_at,
                             input bit rand_clr);
        logic clr;
        for (int i = first; i <= last; i++) begin
            clr = (i == clr_at) || (rand_clr && $urandom_range(0, 31) == 0);
            send_byte(frame_buf[i], clr);
        end
    endtask

    task automatic send_random_bytes(input int count);
        logic [BYTE_W-1:0] b;
        logic              clr;
        repeat (count) begin
            b   = BYTE_W'($urandom_range(0, 255));
            clr = ($urandom_range(0, 31) == 0);
            send_byte(b, clr);
        end
    endtask

    task automatic realign();
        if (frame_pos != 0) begin
            send_random_bytes(FRAME_LEN - frame_pos);
        end
    endtask

    function automatic logic [BYTE_W-1:0] spoil(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] flip;
        flip = BYTE_W'($urandom_range(1, 255));
        return v ^ flip;
    endfunction

    function automatic void build_frame(input bit hdr_ok, input bit tail_ok, input bit chk_ok,
                                        input fill_kind_t fill, input logic [MODE_W-1:0] code);
        logic [CODE_W-1:0] sum, crc, field, flip;
        logic [BYTE_W-1:0] x, b;
        int                hbad, tbad;
        sum = '0;
        x   = '0;
        crc = CRC_INIT;
        for (int i = 2; i < FRAME_LEN - 4; i++) begin
            case (fill)
                FILL_ZERO: b = '0;
                FILL_ONES: b = '1;
                default:   b = BYTE_W'($urandom_range(0, 255));
            endcase
            frame_buf[i] = b;
            sum = sum + {{(CODE_W - BYTE_W){1'b0}}, b};
            x   = x ^ b;
            crc = crc_fold_byte(crc, b);
        end
        field = CODE_W'($urandom_range(0, 65535));
        case (code)
            MODE_SUM16: field = sum;
            MODE_XOR8:  field[BYTE_W-1:0] = x;
            MODE_CRC16: field = crc;
            default: ;
        endcase
        if (!chk_ok) begin
            if (code == MODE_XOR8) begin
                field[BYTE_W-1:0] = spoil(field[BYTE_W-1:0]);
            end else begin
                flip  = CODE_W'($urandom_range(1, 65535));
                field = field ^ flip;
            end
        end
        frame_buf[FRAME_LEN-4] = field[CODE_W-1:BYTE_W];
        frame_buf[FRAME_LEN-3] = field[BYTE_W-1:0];
        hbad = hdr_ok ? 0 : int'($urandom_range(1, 3));
        tbad = tail_ok ? 0 : int'($urandom_range(1, 3));
        frame_buf[0]           = hbad[0] ? spoil(exp_hdr0) : exp_hdr0;
        frame_buf[1]           = hbad[1] ? spoil(exp_hdr1) : exp_hdr1;
        frame_buf[FRAME_LEN-2] = tbad[0] ? spoil(exp_tail0) : exp_tail0;
        frame_buf[FRAME_LEN-1] = tbad[1] ? spoil(exp_tail1) : exp_tail1;
    endfunction

    task automatic send_frame(input bit hdr_ok, input bit tail_ok, input bit chk_ok,
                              input fill_kind_t fill, input int clr_at);
        build_frame(hdr_ok, tail_ok, chk_ok, fill, cur_mode);
        send_span(0, FRAME_LEN - 1, clr_at, 1'b0);
    endtask

    task automatic check_field(input string name, input logic [STAT_W-1:0] expv,
                               input logic [STAT_W-1:0] actv);
        if (actv !== expv) begin
            mismatches++;
            $display("%0t %s expected %0h actual %0h", $time, name, expv, actv);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (frame_reports.size() == 0) begin
                mismatches++;
                $display("%0t result beat with no frame pending, expected none actual %0h",
                         $time, m_error_status);
            end else begin
                want = frame_reports.pop_front();
                check_field("header_bad", STAT_W'(want.header_bad), STAT_W'(m_header_bad));
                check_field("tail_bad", STAT_W'(want.tail_bad), STAT_W'(m_tail_bad));
                check_field("check_bad", STAT_W'(want.check_bad), STAT_W'(m_check_bad));
                check_field("error_status", want.status, m_error_status);
            end
        end
    end

    // result side ready, with per-result stalls and an optional long hold
    initial begin
        int n;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request > 0) begin
                m_ready <= 1'b0;
                repeat (hold_request) @(negedge aclk);
                hold_request = 0;
            end else if (!rx_stall) begin
                m_ready <= 1'b1;
            end else if (m_valid && !m_ready) begin
                n = $urandom_range(0, 7);
                repeat (n) @(negedge aclk);
                m_ready <= 1'b1;
            end else if (!(m_valid && m_ready)) begin
                m_ready <= 1'b0;
            end
        end
    end

    task automatic test_reset_defaults();
        send_frame(1'b1, 1'b1, 1'b1, FILL_ZERO, NO_CLEAR);
        send_frame(1'b0, 1'b0, 1'b1, FILL_RANDOM, NO_CLEAR);
        drain();
    endtask

    task automatic test_field_extremes();
        write_reg(REG_HEADER_FIRST, 8'hFF);
        write_reg(REG_HEADER_SECOND, 8'h00);
        write_reg(REG_TAIL_FIRST, 8'h00);
        write_reg(REG_TAIL_SECOND, 8'hFF);
        write_reg(REG_CHECK_MODE, BYTE_W'(MODE_CRC16));
        send_frame(1'b1, 1'b1, 1'b1, FILL_ONES, NO_CLEAR);
        send_frame(1'b1, 1'b1, 1'b1, FILL_ZERO, NO_CLEAR);
        drain();
        write_reg(REG_CHECK_MODE, BYTE_W'(MODE_SUM16));
        send_frame(1'b1, 1'b1, 1'b1, FILL_ONES, NO_CLEAR);
        drain();
        write_reg(REG_HEADER_FIRST, 8'h00);
        write_reg(REG_HEADER_SECOND, 8'hFF);
        write_reg(REG_TAIL_FIRST, 8'hFF);
        write_reg(REG_TAIL_SECOND, 8'h00);
        write_reg(REG_CHECK_MODE, BYTE_W'(MODE_XOR8));
        send_frame(1'b1, 1'b1, 1'b1, FILL_ONES, NO_CLEAR);
        send_frame(1'b0, 1'b0, 1'b0, FILL_ZERO, NO_CLEAR);
        drain();
    endtask

    task automatic test_check_codes();
        logic [MODE_W-1:0] modes[4] = '{MODE_NONE, MODE_SUM16, MODE_XOR8, MODE_CRC16};
        foreach (modes[i]) begin
            write_reg(REG_CHECK_MODE, BYTE_W'(modes[i]));
            send_frame(1'b1, 1'b1, 1'b1, FILL_RANDOM, NO_CLEAR);
            send_frame(1'b1, 1'b1, 1'b0, FILL_RANDOM, NO_CLEAR);
            drain();
        end
    endtask

    task automatic test_unused_indexes();
        logic [BYTE_W-1:0] data;
        data = {{(BYTE_W - MODE_W){1'b1}}, MODE_XOR8};
        write_reg(REG_CHECK_MODE, data);
        for (int idx = REG_CHECK_MODE + 1; idx < (1 << INDEX_W); idx++) begin
            data = BYTE_W'($urandom_range(0, 255));
            write_reg(INDEX_W'(idx), data);
        end
        send_frame(1'b1, 1'b1, 1'b1, FILL_RANDOM, NO_CLEAR);
        send_frame(1'b1, 1'b0, 1'b1, FILL_RANDOM, NO_CLEAR);
        drain();
    endtask

    task automatic test_mid_frame_updates();
        logic [BYTE_W-1:0] v;
        // mode picked up at the low check byte
        write_reg(REG_CHECK_MODE, BYTE_W'(MODE_SUM16));
        build_frame(1'b1, 1'b1, 1'b1, FILL_RANDOM, MODE_CRC16);
        send_span(0, FRAME_LEN - 4, NO_CLEAR, 1'b0);
        drain();
        write_reg(REG_CHECK_MODE, BYTE_W'(MODE_CRC16));
        send_span(FRAME_LEN - 3, FRAME_LEN - 1, NO_CLEAR, 1'b0);
        // header and tail compared against the value at arrival
        build_frame(1'b1, 1'b1, 1'b1, FILL_RANDOM, MODE_CRC16);
        send_span(0, 0, NO_CLEAR, 1'b0);
        drain();
        v = spoil(exp_hdr1);
        write_reg(REG_HEADER_SECOND, v);
        frame_buf[1] = v;
        send_span(1, FRAME_LEN - 2, NO_CLEAR, 1'b0);
        drain();
        v = spoil(exp_tail1);
        write_reg(REG_TAIL_SECOND, v);
        frame_buf[FRAME_LEN-1] = v;
        send_span(FRAME_LEN - 1, FRAME_LEN - 1, NO_CLEAR, 1'b0);
        drain();
    endtask

    task automatic test_sticky_status();
        write_reg(REG_CHECK_MODE, BYTE_W'(MODE_CRC16));
        send_frame(1'b0, 1'b1, 1'b1, FILL_RANDOM, NO_CLEAR);
        send_frame(1'b1, 1'b0, 1'b1, FILL_RANDOM, NO_CLEAR);
        send_frame(1'b1, 1'b1, 1'b0, FILL_RANDOM, NO_CLEAR);
        send_frame(1'b1, 1'b1, 1'b1, FILL_RANDOM, 5);
        send_frame(1'b0, 1'b0, 1'b0, FILL_RANDOM, NO_CLEAR);
        send_frame(1'b0, 1'b1, 1'b1, FILL_RANDOM, FRAME_LEN - 1);
        send_frame(1'b1, 1'b1, 1'b1, FILL_RANDOM, 0);
        drain();
    endtask

    task automatic test_frame_slip();
        send_random_bytes(7);
        send_frame(1'b1, 1'b1, 1'b1, FILL_RANDOM, NO_CLEAR);
        send_frame(1'b1, 1'b1, 1'b1, FILL_RANDOM, NO_CLEAR);
        realign();
        send_frame(1'b1, 1'b1, 1'b1, FILL_RANDOM, NO_CLEAR);
        drain();
    endtask

    task automatic test_backpressure();
        tx_gaps      = 1'b0;
        rx_stall     = 1'b0;
        hold_request = HOLD_CYCLES;
        repeat (4) send_frame(1'b1, 1'b0, 1'b1, FILL_RANDOM, NO_CLEAR);
        drain();
        tx_gaps  = 1'b1;
        rx_stall = 1'b1;
    endtask

    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic test_random_traffic();
        logic [BYTE_W-1:0] data;
        fill_kind_t        fill;
        int                frames;
        int                r;
        while (bytes_sent < ITEM_TARGET) begin
            write_reg(REG_HEADER_FIRST, pick_byte());
            write_reg(REG_HEADER_SECOND, pick_byte());
            write_reg(REG_TAIL_FIRST, pick_byte());
            write_reg(REG_TAIL_SECOND, pick_byte());
            data = BYTE_W'($urandom_range(0, 255));
            write_reg(REG_CHECK_MODE, data);
            tx_gaps  = ($urandom_range(0, 3) != 0);
            rx_stall = ($urandom_range(0, 3) != 0);
            frames   = $urandom_range(3, 8);
            repeat (frames) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_random_bytes($urandom_range(1, FRAME_LEN - 1));
                end else begin
                    if ($urandom_range(0, 3) != 0) begin
                        realign();
                    end
                    r    = $urandom_range(0, 15);
                    fill = (r == 0) ? FILL_ZERO : (r == 1) ? FILL_ONES : FILL_RANDOM;
                    build_frame($urandom_range(0, 4) != 0, $urandom_range(0, 4) != 0,
                                $urandom_range(0, 4) != 0, fill, cur_mode);
                    send_span(0, FRAME_LEN - 1, NO_CLEAR, 1'b1);
                end
            end
            drain();
        end
    endtask

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_rx_byte      = '0;
        s_clear_errors = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        bytes_sent     = 0;
        mismatches     = 0;
        hold_request   = 0;
        tx_gaps        = 1'b1;
        rx_stall       = 1'b1;
        clear_tracking();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_field_extremes();
        test_check_codes();
        test_unused_indexes();
        test_mid_frame_updates();
        test_sticky_status();
        test_frame_slip();
        test_backpressure();
        test_random_traffic();

        drain();
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && frame_reports.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/sfc_pkg.sv
hdl/sfc_position.sv
hdl/sfc_check.sv
hdl/serial_frame_checker_unit.sv
verif/tb_serial_frame_checker_unit.sv
